// ----- rtl/core/weo_pkg.sv -----
// Shared constants, state type and arctangent table for the wheel encoder odometry block.
package weo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 30;
    localparam int ATAN_IW      = $clog2(ATAN_ENTRIES);
    localparam int ITER_W       = $clog2(CORDIC_STEPS);

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_METERS_PER_TICK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PER_TICK  = CFG_IDX_W'(1);

    localparam logic [31:0] MPT_RESET = 32'd7906077;
    localparam logic [31:0] APT_RESET = 32'd1258291;
    localparam logic [31:0] GAIN_Q32  = 32'd2608131497;
    localparam logic [36:0] DIST_LIMIT = 37'd68719476736;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIST_HI,
        ST_DIST_LO,
        ST_DIST_SUM,
        ST_HEAD_LO,
        ST_HEAD_SUM,
        ST_GAIN_LO,
        ST_GAIN_SUM,
        ST_ROTATE,
        ST_ACCUM,
        ST_EMIT
    } t_state;

    function automatic logic [31:0] atan_lookup(input logic [ATAN_IW-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/wheel_encoder_odometry_top.sv -----
// Wheel encoder odometry: deltas, distance and heading, CORDIC rotation, saturating pose.
// One item is processed at a time, through the rotation loop in the single shift-add unit
// plus six passes through the shared 32x32 multiplier; a new item is taken only after the
// previous one has left the emit state.
// Input ready only while idle; a pending result may wait while the next item is taken.
// Reset (synchronous, active low) clears pose, heading and last counts, loads config defaults.
module wheel_encoder_odometry_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic        [31:0]               i_sample_time,
    input  logic signed [31:0]               i_front_left_count,
    input  logic signed [31:0]               i_front_right_count,
    input  logic signed [31:0]               i_rear_left_count,
    input  logic signed [31:0]               i_rear_right_count,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic        [31:0]               o_out_time,
    output logic signed [31:0]               o_pos_x,
    output logic signed [31:0]               o_pos_y,
    output logic        [31:0]               o_heading,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic        [weo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [31:0]               i_cfg_data
);
    import weo_pkg::*;

    localparam logic signed [40:0] POS_MAX = 41'sd2147483647;
    localparam logic signed [40:0] POS_MIN = -41'sd2147483648;

    t_state r_state, n_state;

    logic [31:0] r_mpt, r_apt;
    logic [31:0] r_prev [4];
    logic signed [31:0] r_x_acc, r_y_acc;
    logic [31:0] r_heading;
    logic r_out_valid;

    logic [31:0] r_time;
    logic [31:0] r_d [4];
    logic [33:0] r_mag, r_diff;
    logic r_neg;
    logic [63:0] r_prod;
    logic [61:0] r_acc;
    logic [15:0] r_plo;
    logic [36:0] r_dist;
    logic [31:0] r_mid;
    logic signed [47:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic [ITER_W-1:0] r_iter;
    logic [31:0] r_o_time, r_o_heading;
    logic signed [31:0] r_o_x, r_o_y;

    logic [31:0] mul_a, mul_b;
    logic in_accept, emit_go;

    logic [32:0] sum_l, sum_r;
    logic [33:0] s_tot, diff;
    logic [61:0] acc_sum;
    logic [59:0] dist_q;
    logic [33:0] p_bits;
    logic [47:0] v48;
    logic signed [33:0] mid_s;
    logic signed [47:0] x_init;
    logic signed [33:0] z_init;
    logic flip;
    logic signed [47:0] xs, ys;
    logic signed [33:0] atan_v;
    logic signed [39:0] x_step, y_step;
    logic signed [40:0] x_sum, y_sum;
    logic signed [31:0] x_sat, y_sat;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;
    assign emit_go     = (r_time == 32'd0) || !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (in_accept) n_state = ST_SUM;
            ST_SUM:      n_state = ST_DIST_HI;
            ST_DIST_HI:  n_state = ST_DIST_LO;
            ST_DIST_LO:  n_state = ST_DIST_SUM;
            ST_DIST_SUM: n_state = ST_HEAD_LO;
            ST_HEAD_LO:  n_state = ST_HEAD_SUM;
            ST_HEAD_SUM: n_state = ST_GAIN_LO;
            ST_GAIN_LO:  n_state = ST_GAIN_SUM;
            ST_GAIN_SUM: n_state = ST_ROTATE;
            ST_ROTATE:   if (r_iter == ITER_W'(CORDIC_STEPS - 1)) n_state = ST_ACCUM;
            ST_ACCUM:    n_state = ST_EMIT;
            ST_EMIT:     if (emit_go) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs: ready and multiplier operand select
    always_comb begin
        o_in_ready = 1'b0;
        mul_a      = 32'd0;
        mul_b      = 32'd0;
        unique case (r_state)
            ST_IDLE:     o_in_ready = 1'b1;
            ST_DIST_HI: begin
                mul_a = {14'd0, r_mag[33:16]};
                mul_b = r_mpt;
            end
            ST_DIST_LO: begin
                mul_a = {16'd0, r_mag[15:0]};
                mul_b = r_mpt;
            end
            ST_DIST_SUM: begin
                mul_a = {14'd0, r_diff[33:16]};
                mul_b = r_apt;
            end
            ST_HEAD_LO: begin
                mul_a = {16'd0, r_diff[15:0]};
                mul_b = r_apt;
            end
            ST_HEAD_SUM: begin
                mul_a = {3'd0, r_dist[36:8]};
                mul_b = GAIN_Q32;
            end
            ST_GAIN_LO: begin
                mul_a = {16'd0, r_dist[7:0], 8'd0};
                mul_b = GAIN_Q32;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // datapath arithmetic
    always_comb begin
        sum_l   = {r_d[0][31], r_d[0]} + {r_d[2][31], r_d[2]};
        sum_r   = {r_d[1][31], r_d[1]} + {r_d[3][31], r_d[3]};
        s_tot   = {sum_l[32], sum_l} + {sum_r[32], sum_r};
        diff    = {sum_r[32], sum_r} - {sum_l[32], sum_l};
        acc_sum = r_acc + {14'd0, r_prod[63:16]};
        dist_q  = r_acc[61:2];
        p_bits  = {r_acc[17:0], r_plo};
        v48     = {2'b00, acc_sum[61:16]};
        mid_s   = {{2{r_mid[31]}}, r_mid};
        flip    = 1'b0;
        z_init  = mid_s;
        if (mid_s > 34'sd1073741824) begin
            flip   = 1'b1;
            z_init = mid_s - 34'sd2147483648;
        end else if (mid_s < -34'sd1073741824) begin
            flip   = 1'b1;
            z_init = mid_s + 34'sd2147483648;
        end
        x_init  = (r_neg ^ flip) ? -v48 : v48;
        xs      = r_x >>> r_iter;
        ys      = r_y >>> r_iter;
        atan_v  = {2'b00, atan_lookup(ATAN_IW'(r_iter))};
        x_step  = r_x[47:8];
        y_step  = r_y[47:8];
        x_sum   = {{9{r_x_acc[31]}}, r_x_acc} + {x_step[39], x_step};
        y_sum   = {{9{r_y_acc[31]}}, r_y_acc} + {y_step[39], y_step};
        if (x_sum > POS_MAX)      x_sat = 32'sh7fffffff;
        else if (x_sum < POS_MIN) x_sat = 32'sh80000000;
        else                      x_sat = x_sum[31:0];
        if (y_sum > POS_MAX)      y_sat = 32'sh7fffffff;
        else if (y_sum < POS_MIN) y_sat = 32'sh80000000;
        else                      y_sat = y_sum[31:0];
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_mpt       <= MPT_RESET;
            r_apt       <= APT_RESET;
            r_prev[0]   <= 32'd0;
            r_prev[1]   <= 32'd0;
            r_prev[2]   <= 32'd0;
            r_prev[3]   <= 32'd0;
            r_x_acc     <= 32'sd0;
            r_y_acc     <= 32'sd0;
            r_heading   <= 32'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_METERS_PER_TICK: r_mpt <= i_cfg_data;
                    REG_ANGLE_PER_TICK:  r_apt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_prev[0] <= i_front_left_count;
                r_prev[1] <= i_front_right_count;
                r_prev[2] <= i_rear_left_count;
                r_prev[3] <= i_rear_right_count;
            end
            if (r_state == ST_GAIN_LO) r_heading <= r_heading + p_bits[32:1];
            if (r_state == ST_ACCUM) begin
                r_x_acc <= x_sat;
                r_y_acc <= y_sat;
            end
            if (r_state == ST_EMIT && r_time != 32'd0 && emit_go) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)                   r_out_valid <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_accept) begin
            r_time <= i_sample_time;
            r_d[0] <= i_front_left_count  - r_prev[0];
            r_d[1] <= i_front_right_count - r_prev[1];
            r_d[2] <= i_rear_left_count   - r_prev[2];
            r_d[3] <= i_rear_right_count  - r_prev[3];
        end
        case (r_state)
            ST_SUM: begin
                r_neg  <= s_tot[33];
                r_mag  <= s_tot[33] ? -s_tot : s_tot;
                r_diff <= diff;
            end
            ST_DIST_LO:  r_acc <= r_prod[61:0];
            ST_DIST_SUM: r_acc <= acc_sum;
            ST_HEAD_LO: begin
                r_dist <= (dist_q > 60'(DIST_LIMIT)) ? DIST_LIMIT : dist_q[36:0];
                r_acc  <= r_prod[61:0];
            end
            ST_HEAD_SUM: begin
                r_acc <= acc_sum;
                r_plo <= r_prod[15:0];
            end
            ST_GAIN_LO: begin
                r_mid <= r_heading + p_bits[33:2];
                r_acc <= r_prod[61:0];
            end
            ST_GAIN_SUM: begin
                r_x    <= x_init;
                r_y    <= 48'sd0;
                r_z    <= z_init;
                r_iter <= '0;
            end
            ST_ROTATE: begin
                if (!r_z[33]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_v;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_v;
                end
                r_iter <= r_iter + 1'b1;
            end
            default: ;
        endcase
        if (r_state == ST_EMIT && r_time != 32'd0 && emit_go) begin
            r_o_time    <= r_time;
            r_o_x       <= r_x_acc;
            r_o_y       <= r_y_acc;
            r_o_heading <= r_heading;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_time  = r_o_time;
    assign o_pos_x     = r_o_x;
    assign o_pos_y     = r_o_y;
    assign o_heading   = r_o_heading;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == ST_SUM)
        else $error("accepted item did not start processing");

    a_iter_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_GAIN_SUM |=> r_iter == '0)
        else $error("rotation counter not cleared");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_EMIT)
        else $error("result raised outside emit");

    a_zero_time_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_time == 32'd0 && !r_out_valid) |=> !r_out_valid)
        else $error("result produced for zero timestamp");

    a_dist_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_HEAD_SUM |-> r_dist <= DIST_LIMIT)
        else $error("distance above clamp");

endmodule
